>>> rtl/ssfb_pkg.sv
// Shared types, constants and font table for the seven-segment frame builder.
`timescale 1ns / 1ps
package ssfb_pkg;

    // Request fields
    localparam int OP_W     = 2;
    localparam int NUMBER_W = 31;
    localparam int POS_W    = 4;
    localparam int GLYPH_W  = 5;
    localparam int BRIGHT_W = 3;

    // Binary-to-BCD pipeline: number padded to NUM_W, STAGE_BITS bits shifted per stage
    localparam int NUM_W      = 32;
    localparam int STAGE_BITS = 8;
    localparam int BCD_STAGES = NUM_W / STAGE_BITS;

    localparam int DIGITS_DEF      = 8;
    localparam int CLEAR_BYTES_DEF = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_NUMBER  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
    localparam logic [OP_W-1:0] OP_CONTROL = 2'd3;

    // Controller command bytes
    localparam logic [7:0] CMD_DATA_AUTO  = 8'h40;
    localparam logic [7:0] CMD_DATA_FIXED = 8'h44;
    localparam logic [7:0] CMD_ADDR       = 8'hC0;
    localparam logic [7:0] CMD_CTRL       = 8'h80;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [POS_W-1:0]    position;
        logic [GLYPH_W-1:0]  glyph;
        logic                display_on;
        logic [BRIGHT_W-1:0] brightness;
    } req_t;

    function automatic logic [7:0] font_lookup(input logic [GLYPH_W-1:0] idx);
        logic [7:0] seg;
        case (idx)
            5'd0:    seg = 8'h3F;
            5'd1:    seg = 8'h06;
            5'd2:    seg = 8'h5B;
            5'd3:    seg = 8'h4F;
            5'd4:    seg = 8'h66;
            5'd5:    seg = 8'h6D;
            5'd6:    seg = 8'h7D;
            5'd7:    seg = 8'h07;
            5'd8:    seg = 8'h7F;
            5'd9:    seg = 8'h6F;
            5'd10:   seg = 8'h77;
            5'd11:   seg = 8'h7C;
            5'd12:   seg = 8'h39;
            5'd13:   seg = 8'h5E;
            5'd14:   seg = 8'h79;
            5'd15:   seg = 8'h71;
            5'd16:   seg = 8'h3D;
            5'd17:   seg = 8'h76;
            5'd18:   seg = 8'h00;
            5'd19:   seg = 8'h40;
            5'd20:   seg = 8'h80;
            5'd21:   seg = 8'h63;
            5'd22:   seg = 8'h78;
            5'd23:   seg = 8'h1E;
            5'd24:   seg = 8'h38;
            default: seg = 8'h00;   // out of font range: blank
        endcase
        return seg;
    endfunction

endpackage

>>> rtl/seven_segment_frame_builder_unit.sv
// Top level of the seven-segment frame builder: BCD conversion pipeline and byte sequencer.
`timescale 1ns / 1ps
// Takes one display request per input beat and emits the strobe-framed command bytes for an
// 8-digit seven-segment LED controller, one byte per output beat. A request first runs
// through BCD_STAGES registered double-dabble stages (8 binary bits each) and then into the
// byte sequencer, which feeds an output register. The single output byte port sets the
// pace: a request occupies the sequencer until all its bytes are out - 2 + 2*DIGITS (18)
// for show number, 3 for single position write, 2 + CLEAR_BYTES (34) for clear, 1 for
// display control - and consecutive requests stream with no gap. Input beats keep flowing
// into the pipeline while the sequencer is busy until all stages hold a request. Output
// tuser[0] marks strobe low before the byte, tuser[1] strobe high after it; tlast marks
// the final byte of each request. Only the low DIGITS decimal digits of number are shown.
module seven_segment_frame_builder_unit #(
    parameter int DIGITS      = ssfb_pkg::DIGITS_DEF,
    parameter int CLEAR_BYTES = ssfb_pkg::CLEAR_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // number[30:0], position[34:31], glyph[39:35],
                                        // display_on[40], brightness[43:41], zero pad
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    // Byte channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic [1:0]  m_axis_tuser,   // frame_start[0], frame_end[1]
    output logic        m_axis_tlast    // last
);
    import ssfb_pkg::*;

    localparam int BCD_W = DIGITS * 4;

    // Handshake and payload between pipeline stages; index 0 is the input port
    logic               stg_valid [BCD_STAGES+1];
    logic               stg_ready [BCD_STAGES+1];
    req_t               stg_req   [BCD_STAGES+1];
    logic [NUM_W-1:0]   stg_bin   [BCD_STAGES+1];
    logic [BCD_W-1:0]   stg_bcd   [BCD_STAGES+1];

    // Unpack the request beat
    assign stg_valid[0]           = s_axis_tvalid;
    assign s_axis_tready          = stg_ready[0];
    assign stg_req[0].op          = s_axis_tuser;
    assign stg_req[0].position    = s_axis_tdata[34:31];
    assign stg_req[0].glyph       = s_axis_tdata[39:35];
    assign stg_req[0].display_on  = s_axis_tdata[40];
    assign stg_req[0].brightness  = s_axis_tdata[43:41];
    assign stg_bin[0]             = {{(NUM_W-NUMBER_W){1'b0}}, s_axis_tdata[NUMBER_W-1:0]};
    assign stg_bcd[0]             = '0;

    // Binary-to-BCD pipeline
    for (genvar g = 0; g < BCD_STAGES; g++) begin : g_bcd
        ssfb_bcd_stage #(
            .DIGITS (DIGITS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_req    (stg_req[g]),
            .in_bin    (stg_bin[g]),
            .in_bcd    (stg_bcd[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_req   (stg_req[g+1]),
            .out_bin   (stg_bin[g+1]),
            .out_bcd   (stg_bcd[g+1])
        );
    end

    // Byte sequencer and output register
    ssfb_emitter #(
        .DIGITS      (DIGITS),
        .CLEAR_BYTES (CLEAR_BYTES)
    ) u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stg_valid[BCD_STAGES]),
        .in_ready (stg_ready[BCD_STAGES]),
        .in_req   (stg_req[BCD_STAGES]),
        .in_bcd   (stg_bcd[BCD_STAGES]),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

    // stg_bin of the last stage is fully shifted out and unused beyond this point
    logic unused_bin;
    assign unused_bin = ^stg_bin[BCD_STAGES];

endmodule

>>> rtl/ssfb_bcd_stage.sv
// One registered double-dabble stage: shifts STAGE_BITS binary bits into the BCD digits.
`timescale 1ns / 1ps
module ssfb_bcd_stage #(
    parameter int DIGITS = ssfb_pkg::DIGITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ssfb_pkg::req_t             in_req,
    input  logic [ssfb_pkg::NUM_W-1:0] in_bin,
    input  logic [DIGITS*4-1:0]        in_bcd,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ssfb_pkg::req_t             out_req,
    output logic [ssfb_pkg::NUM_W-1:0] out_bin,
    output logic [DIGITS*4-1:0]        out_bcd
);
    import ssfb_pkg::*;

    localparam int BCD_W = DIGITS * 4;

    logic               valid_reg, valid_next;
    req_t               req_reg;
    logic [NUM_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;

    assign in_ready = !valid_reg || out_ready;

    // Add-3 correction then shift, STAGE_BITS times; digits above DIGITS fall off
    always_comb begin
        logic [NUM_W-1:0] n;
        logic [BCD_W-1:0] b;
        n = in_bin;
        b = in_bcd;
        for (int s = 0; s < STAGE_BITS; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (b[d*4 +: 4] >= 4'd5) begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], n[NUM_W-1]};
            n = {n[NUM_W-2:0], 1'b0};
        end
        bin_next = n;
        bcd_next = b;
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            req_reg <= in_req;
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_req   = req_reg;
    assign out_bin   = bin_reg;
    assign out_bcd   = bcd_reg;

endmodule

>>> rtl/ssfb_emitter.sv
// Byte sequencer: walks a request's bytes into an output register, one per cycle unless stalled.
`timescale 1ns / 1ps
module ssfb_emitter #(
    parameter int DIGITS      = ssfb_pkg::DIGITS_DEF,
    parameter int CLEAR_BYTES = ssfb_pkg::CLEAR_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ssfb_pkg::req_t      in_req,
    input  logic [DIGITS*4-1:0] in_bcd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    import ssfb_pkg::*;

    localparam int BCD_W   = DIGITS * 4;
    localparam int LEN_NUM = 2 + 2 * DIGITS;
    localparam int LEN_CLR = 2 + CLEAR_BYTES;
    localparam int LEN_MAX = (LEN_NUM > LEN_CLR) ? LEN_NUM : LEN_CLR;
    localparam int IDX_W   = $clog2(LEN_MAX);
    localparam int DIG_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic               busy_reg, busy_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    req_t               cur_req_reg;
    logic [BCD_W-1:0]   cur_bcd_reg;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic [1:0]         out_user_reg, out_user_next;
    logic               out_last_reg, out_last_next;

    logic [IDX_W-1:0]   last_idx;
    logic               cur_last;
    logic               out_free;
    logic               emit;
    logic               load;
    logic [IDX_W-1:0]   data_idx;
    logic [DIG_W-1:0]   nib_sel;
    logic [3:0]         digit;
    logic [7:0]         byte_val;

    always_comb begin
        case (cur_req_reg.op)
            OP_NUMBER:  last_idx = IDX_W'(LEN_NUM - 1);
            OP_WRITE:   last_idx = IDX_W'(2);
            OP_CLEAR:   last_idx = IDX_W'(LEN_CLR - 1);
            OP_CONTROL: last_idx = '0;
            default:    last_idx = '0;
        endcase
    end

    assign cur_last = (idx_reg == last_idx);
    assign out_free = !out_valid_reg || m_tready;
    assign emit     = busy_reg && out_free;
    assign in_ready = !busy_reg || (emit && cur_last);
    assign load     = in_valid && in_ready;

    // Data bytes of a number frame alternate glyph, zero; digits most significant first
    assign data_idx = idx_reg - IDX_W'(2);
    assign nib_sel  = DIG_W'(DIGITS - 1) - DIG_W'(data_idx[IDX_W-1:1]);
    assign digit    = cur_bcd_reg[nib_sel*4 +: 4];

    always_comb begin
        byte_val = 8'h00;
        if (idx_reg == '0) begin
            case (cur_req_reg.op)
                OP_WRITE:   byte_val = CMD_DATA_FIXED;
                OP_CONTROL: byte_val = CMD_CTRL | {4'd0, cur_req_reg.display_on,
                                                   cur_req_reg.brightness};
                default:    byte_val = CMD_DATA_AUTO;
            endcase
        end else if (idx_reg == IDX_W'(1)) begin
            if (cur_req_reg.op == OP_WRITE) begin
                byte_val = CMD_ADDR | {4'd0, cur_req_reg.position};
            end else begin
                byte_val = CMD_ADDR;
            end
        end else begin
            case (cur_req_reg.op)
                OP_WRITE:  byte_val = font_lookup(cur_req_reg.glyph);
                OP_NUMBER: byte_val = data_idx[0] ? 8'h00 : font_lookup({1'b0, digit});
                default:   byte_val = 8'h00;
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = byte_val;
            // tuser[0] frame start, tuser[1] frame end
            out_user_next  = {(idx_reg == '0) || cur_last,
                              (idx_reg == '0) || (idx_reg == IDX_W'(1))};
            out_last_next  = cur_last;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (emit) begin
            busy_next = !cur_last;
            idx_next  = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_req_reg <= in_req;
            cur_bcd_reg <= in_bcd;
        end
        out_byte_reg <= out_byte_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_idx_in_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg <= last_idx)
        else $error("byte index past end of stream");

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_last_reg |-> out_user_reg[1])
        else $error("final beat does not close a frame");

    a_take_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && in_ready |-> emit && cur_last)
        else $error("new request taken mid-stream");

    a_first_beat_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> busy_reg && idx_reg == '0)
        else $error("loaded request does not start at first byte");
`endif

endmodule
